// ----- rtl/mdxc_pkg.sv -----
// ----------------------------------------------------------------------------
// mdxc_pkg
// Types and constants shared by the frame deframer with XOR check.
// ----------------------------------------------------------------------------
package mdxc_pkg;

    localparam int BYTE_W  = 8;
    localparam int POS_W   = 7;
    localparam int STAT_W  = 2;

    localparam logic [BYTE_W-1:0] XOR_SEED     = 8'hFF;
    localparam logic [1:0]        LEN_CODE_EXT = 2'd3;
    localparam logic [POS_W-1:0]  MIN_LEN_BYTE = 7'd3;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    typedef enum logic [STAT_W-1:0] {
        ST_PENDING  = 2'd0,
        ST_GOOD     = 2'd1,
        ST_BAD      = 2'd2,
        ST_BAD_LEN  = 2'd3
    } frame_status_t;

    typedef struct packed {
        phase_t            phase;
        logic [POS_W-1:0]  expected_length;
        logic [POS_W-1:0]  byte_count;
        logic [BYTE_W-1:0] running_xor;
    } deframe_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [POS_W-1:0]  position;
        logic              in_frame;
        logic              frame_end;
        frame_status_t     frame_status;
        logic [POS_W-1:0]  frame_length;
    } deframe_result_t;

endpackage

// ----- rtl/mdxc_step.sv -----
// ----------------------------------------------------------------------------
// mdxc_step
// Next-state and result logic for one received byte.
// ----------------------------------------------------------------------------
module mdxc_step
    import mdxc_pkg::*;
(
    input  logic [BYTE_W-1:0] rx_byte,
    input  deframe_state_t    cur,
    output deframe_state_t    nxt,
    output deframe_result_t   res
);

    logic [1:0]       len_code;
    logic [POS_W:0]   pos_plus_one;
    logic             last_byte;

    assign len_code     = rx_byte[6:5];
    assign pos_plus_one = {1'b0, cur.byte_count} + {{POS_W{1'b0}}, 1'b1};
    assign last_byte    = pos_plus_one >= {1'b0, cur.expected_length};

    always_comb begin
        nxt              = cur;
        res.data_byte    = rx_byte;
        res.position     = '0;
        res.in_frame     = 1'b0;
        res.frame_end    = 1'b0;
        res.frame_status = ST_PENDING;
        res.frame_length = '0;

        if (rx_byte[7]) begin
            // An opcode always opens a new frame, dropping any open one.
            nxt.running_xor = rx_byte ^ XOR_SEED;
            nxt.byte_count  = 7'd1;
            if (len_code == LEN_CODE_EXT) begin
                nxt.expected_length = '0;
                nxt.phase           = PH_LEN;
            end else begin
                nxt.expected_length = 7'd2 + {4'd0, len_code, 1'b0};
                nxt.phase           = PH_BODY;
            end
            res.in_frame     = 1'b1;
            res.frame_length = nxt.expected_length;
        end else begin
            unique case (cur.phase)
                PH_LEN: begin
                    res.in_frame = 1'b1;
                    res.position = 7'd1;
                    if (rx_byte[POS_W-1:0] < MIN_LEN_BYTE) begin
                        nxt.phase           = PH_IDLE;
                        nxt.expected_length = '0;
                        nxt.byte_count      = '0;
                        res.frame_status    = ST_BAD_LEN;
                        res.frame_length    = rx_byte[POS_W-1:0];
                    end else begin
                        nxt.expected_length = rx_byte[POS_W-1:0];
                        nxt.running_xor     = cur.running_xor ^ rx_byte;
                        nxt.byte_count      = 7'd2;
                        nxt.phase           = PH_BODY;
                        res.frame_length    = rx_byte[POS_W-1:0];
                    end
                end
                PH_BODY: begin
                    res.in_frame     = 1'b1;
                    res.position     = cur.byte_count;
                    res.frame_length = cur.expected_length;
                    if (last_byte) begin
                        nxt.phase        = PH_IDLE;
                        nxt.byte_count   = '0;
                        res.frame_end    = 1'b1;
                        res.frame_status = (cur.running_xor == rx_byte) ? ST_GOOD : ST_BAD;
                    end else begin
                        nxt.running_xor = cur.running_xor ^ rx_byte;
                        nxt.byte_count  = pos_plus_one[POS_W-1:0];
                    end
                end
                default: begin
                    // Idle: a data byte is echoed as discarded, state holds.
                end
            endcase
        end
    end

endmodule

// ----- rtl/message_deframer_xor_check.sv -----
// ----------------------------------------------------------------------------
// message_deframer_xor_check
// Byte-serial frame deframer with running XOR check byte.
// ----------------------------------------------------------------------------
// Each accepted item is one received byte, and each produces exactly one
// result item in the next cycle: the byte echoed with its position in the
// frame, whether it belongs to a frame, whether it closes the frame, a
// status and the total frame length once known. A byte with bit 7 set
// always starts a new frame; bits 6..5 of it select a length of 2, 4 or 6
// bytes, or say that the next byte carries the length. The check byte must
// equal the XOR of the opcode inverted and all bytes between. One item is
// taken per cycle: the frame state and the result register are updated in
// the same cycle from a short decode, and s_ready stays high while the
// result register is empty or is being drained, so the block keeps full
// rate as long as the downstream side takes results.
// ----------------------------------------------------------------------------
module message_deframer_xor_check
    import mdxc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [BYTE_W-1:0]  s_rx_byte,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [BYTE_W-1:0]  m_data_byte,
    output logic [POS_W-1:0]   m_position,
    output logic               m_in_frame,
    output logic               m_frame_end,
    output logic [STAT_W-1:0]  m_frame_status,
    output logic [POS_W-1:0]   m_frame_length
);

    deframe_state_t  state_reg;
    deframe_state_t  state_next;
    deframe_result_t step_res;
    deframe_result_t res_reg;
    logic            m_valid_reg;
    logic            s_accept;

    // The result register can take a new item when it is empty or when
    // its present item leaves in this same cycle.
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    mdxc_step u_step (
        .rx_byte (s_rx_byte),
        .cur     (state_reg),
        .nxt     (state_next),
        .res     (step_res)
    );

    // Frame state advances only on an accepted item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase           <= PH_IDLE;
            state_reg.expected_length <= '0;
            state_reg.byte_count      <= '0;
            state_reg.running_xor     <= '0;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload needs no reset; it is qualified by m_valid.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            res_reg <= step_res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_data_byte    = res_reg.data_byte;
    assign m_position     = res_reg.position;
    assign m_in_frame     = res_reg.in_frame;
    assign m_frame_end    = res_reg.frame_end;
    assign m_frame_status = res_reg.frame_status;
    assign m_frame_length = res_reg.frame_length;

`ifndef NO_ASSERTIONS
    // A closing byte always returns the frame state to idle.
    a_end_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && step_res.frame_end) |=> (state_reg.phase == PH_IDLE))
        else $error("frame state not idle after closing byte");

    // A discarded byte carries no frame information.
    a_discard_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_in_frame) |->
            (m_position == '0 && !m_frame_end && m_frame_status == ST_PENDING
             && m_frame_length == '0))
        else $error("discarded byte carries frame fields");

    // Only a closing byte reports a checksum verdict.
    a_verdict_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_frame_status == ST_GOOD || m_frame_status == ST_BAD))
            |-> (m_frame_end && m_in_frame))
        else $error("checksum verdict without frame end");

    // An accepted item always yields a result item in the next cycle.
    a_accept_yields: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_valid)
        else $error("accepted item produced no result");
`endif

endmodule
